@@ design/lif_dense_layer_step_assert.svh @@
// ============================================================================
// lif_dense_layer_step_assert.svh
// Assertion macros of the leaky integrate-and-fire layer, used by the sequencer.
// ============================================================================
`ifndef LIF_DENSE_LAYER_STEP_ASSERT_SVH
`define LIF_DENSE_LAYER_STEP_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked check that is switched off while reset is asserted.
`define LIFDL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lifdl assertion failed");
// Clocked check that also holds while reset is asserted.
`define LIFDL_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lifdl assertion failed");
`else
`define LIFDL_ASSERT(lbl, prop)
`define LIFDL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ design/lifdl_pkg.sv @@
// ============================================================================
// lifdl_pkg
// Shared sizes, codes, word types and saturation helper of the LIF layer.
// ============================================================================
package lifdl_pkg;

    // Layer shape.
    localparam int NUM_INPUTS   = 16;
    localparam int NUM_NEURONS  = 16;
    localparam int WEIGHT_DEPTH = NUM_INPUTS * NUM_NEURONS;

    // Only the first 16 inputs can spike; only the first 16 neurons show.
    localparam int SPIKE_ROWS   = (NUM_INPUTS < 16) ? NUM_INPUTS : 16;
    localparam int SHOWN_LANES  = (NUM_NEURONS < 16) ? NUM_NEURONS : 16;

    // Weight row address width inside one neuron lane.
    localparam int ROW_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;

    // Q16.16 constants.
    localparam logic signed [31:0] Q_MINUS_ONE = -32'sd65536;

    // Request codes.
    localparam logic [1:0] REQ_WEIGHT_WR = 2'd0;
    localparam logic [1:0] REQ_MEM_LOAD  = 2'd1;
    localparam logic [1:0] REQ_STEP      = 2'd2;
    localparam logic [1:0] REQ_MEM_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_FIRE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_LEAK_FACTOR    = 2'd1;
    localparam logic [1:0] REG_RESET_LEVEL    = 2'd2;
    localparam logic [1:0] REG_HARD_MODE      = 2'd3;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         entry_index;
        logic signed [31:0] data_value;
        logic [15:0]        in_spikes;
    } req_word_t;

    typedef struct packed {
        logic [15:0]        out_spikes;
        logic signed [31:0] membrane_value;
    } rsp_word_t;

    // Per-cycle commands from the sequencer to every neuron lane.
    typedef struct packed {
        logic             mul;
        logic             norm;
        logic             add;
        logic             spike;
        logic             fire;
        logic [ROW_W-1:0] rd_addr;
    } lane_ctl_t;

    // Result register load request.
    typedef struct packed {
        logic load;
        logic step;
    } rsp_ctl_t;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
            return v[31:0];
        else if (v[33])
            return 32'sh8000_0000;
        else
            return 32'sh7fff_ffff;
    endfunction

endpackage

@@ design/lif_dense_layer_step.sv @@
// ============================================================================
// lif_dense_layer_step
// Dense layer of leaky integrate-and-fire neurons with binary input spikes.
// ============================================================================
//
//  Channel   Handshake               Payload                 Direction
//  request   req_valid / req_ready   req_word (req_word_t)   in
//  result    rsp_valid / rsp_ready   rsp_word (rsp_word_t)   out
//  config    cfg_we                  cfg_index, cfg_data     in
//
//  A weight write, membrane load or membrane read finishes at the accepting
//  edge; its result word is shown in the following cycle.
//  A timestep runs one leak multiply, one normalize, one weight row per
//  cycle read from the per-lane weight RAMs by all neuron lanes at once,
//  and one fire and write-back step.
//  A waiting result holds off requests other than a timestep, and stalls
//  the final fire cycle of a timestep.
//  Reset clears all membrane potentials and loads the register defaults;
//  weights hold unknown values until written.
//
module lif_dense_layer_step
    import lifdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_word_t   req_word,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_word_t   rsp_word,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int RECIP = 65536 / NUM_NEURONS;

    logic signed [31:0] thr_reg;
    logic [16:0]        leak_reg;
    logic signed [31:0] rst_lvl_reg;
    logic               hard_reg;
    logic signed [31:0] reset_eff;

    lane_ctl_t          lane_ctl;
    rsp_ctl_t           rsp_ctl;
    logic               accept;

    logic [24:0]        q_prod;
    logic [15:0]        q_est;
    logic [15:0]        r_est;
    logic [15:0]        wr_row;
    logic [15:0]        wr_lane;
    logic               wr_in_range;

    logic [NUM_NEURONS-1:0] load_en;
    logic [NUM_NEURONS-1:0] weight_we;
    logic [NUM_NEURONS-1:0] fired;
    logic signed [31:0]     mem_value [NUM_NEURONS];
    logic signed [31:0]     read_value;
    logic [15:0]            spikes_merged;

    rsp_word_t rsp_word_reg, rsp_word_next;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= 32'sd65536;
            leak_reg    <= 17'd65536;
            rst_lvl_reg <= '0;
            hard_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIRE_THRESHOLD: thr_reg     <= cfg_data;
                REG_LEAK_FACTOR:    leak_reg    <= cfg_data[16:0];
                REG_RESET_LEVEL:    rst_lvl_reg <= cfg_data;
                REG_HARD_MODE:      hard_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // A reset level of exactly minus one acts as zero.
    assign reset_eff = (rst_lvl_reg == Q_MINUS_ONE) ? '0 : rst_lvl_reg;

    // Sequencer.
    lifdl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req_word.req_type),
        .in_spikes (req_word.in_spikes),
        .rsp_ready (rsp_ready),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .lane_ctl  (lane_ctl),
        .rsp_ctl   (rsp_ctl)
    );

    assign accept = req_valid && req_ready;

    // Split the weight index into input row and neuron lane: reciprocal
    // estimate of the quotient, then one correction step.
    always_comb
    begin
        q_prod = 25'(req_word.entry_index) * 25'(17'(RECIP));
        q_est  = 16'(q_prod[24:16]);
        r_est  = 16'(req_word.entry_index) - q_est * 16'(NUM_NEURONS);
        if (r_est >= 16'(NUM_NEURONS))
        begin
            wr_row  = q_est + 16'd1;
            wr_lane = r_est - 16'(NUM_NEURONS);
        end
        else
        begin
            wr_row  = q_est;
            wr_lane = r_est;
        end
        wr_in_range = (int'(req_word.entry_index) < WEIGHT_DEPTH);
    end

    // Per-lane write strobes.
    always_comb
    begin
        for (int n = 0; n < NUM_NEURONS; n++)
        begin
            load_en[n]   = accept && (req_word.req_type == REQ_MEM_LOAD)
                           && (int'(req_word.entry_index) == n);
            weight_we[n] = accept && (req_word.req_type == REQ_WEIGHT_WR)
                           && wr_in_range && (int'(wr_lane) == n);
        end
    end

    // Neuron lanes.
    for (genvar g = 0; g < NUM_NEURONS; g++)
    begin : g_lane
        lifdl_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (lane_ctl),
            .load_en     (load_en[g]),
            .load_value  (req_word.data_value),
            .weight_we   (weight_we[g]),
            .weight_row  (wr_row[ROW_W-1:0]),
            .weight_data (req_word.data_value),
            .leak        (leak_reg),
            .threshold   (thr_reg),
            .reset_eff   (reset_eff),
            .hard_mode   (hard_reg),
            .mem_value   (mem_value[g]),
            .fired       (fired[g])
        );
    end

    // Merge lane results: membrane read select and visible spike bits.
    always_comb
    begin
        read_value    = '0;
        spikes_merged = '0;
        for (int n = 0; n < NUM_NEURONS; n++)
        begin
            if (int'(req_word.entry_index) == n)
                read_value = mem_value[n];
        end
        for (int n = 0; n < SHOWN_LANES; n++)
        begin
            spikes_merged[n] = fired[n];
        end

        rsp_word_next = '0;
        if (rsp_ctl.step)
            rsp_word_next.out_spikes = spikes_merged;
        else if (req_word.req_type == REQ_MEM_READ)
            rsp_word_next.membrane_value = read_value;
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (rsp_ctl.load)
        begin
            rsp_word_reg <= rsp_word_next;
        end
    end

    assign rsp_word = rsp_word_reg;

endmodule

@@ design/lifdl_ram.sv @@
// ============================================================================
// lifdl_ram
// Generic single-write, single-read memory with a registered read port.
// ============================================================================
module lifdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lifdl_lane.sv @@
// ============================================================================
// lifdl_lane
// One neuron lane: its weight column, membrane register, leak, integrate and fire.
// ============================================================================
module lifdl_lane
    import lifdl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctl_t          ctl,
    input  logic               load_en,
    input  logic signed [31:0] load_value,
    input  logic               weight_we,
    input  logic [ROW_W-1:0]   weight_row,
    input  logic signed [31:0] weight_data,
    input  logic [16:0]        leak,
    input  logic signed [31:0] threshold,
    input  logic signed [31:0] reset_eff,
    input  logic               hard_mode,
    output logic signed [31:0] mem_value,
    output logic               fired
);

    logic signed [31:0] mem_reg, mem_next;
    logic signed [49:0] prod_reg, prod_next;
    logic signed [31:0] acc_reg, acc_next;
    logic signed [31:0] weight;
    logic signed [17:0] leak_s;
    logic signed [49:0] prod_shift;
    logic signed [32:0] sum;
    logic signed [32:0] diff;
    logic               at_threshold;

    // Weights of this neuron, one word per input row.
    lifdl_ram #(
        .WIDTH (32),
        .DEPTH (NUM_INPUTS)
    ) u_weights (
        .clk   (clk),
        .we    (weight_we),
        .waddr (weight_row),
        .wdata (weight_data),
        .raddr (ctl.rd_addr),
        .rdata (weight)
    );

    // Leak product, integration and fire decision.
    always_comb
    begin
        leak_s       = {1'b0, leak};
        prod_next    = mem_reg * leak_s;
        prod_shift   = prod_reg >>> 16;
        sum          = {acc_reg[31], acc_reg} + {weight[31], weight};
        diff         = {acc_reg[31], acc_reg} - {reset_eff[31], reset_eff};
        at_threshold = (acc_reg >= threshold);

        acc_next = acc_reg;
        if (ctl.norm)
        begin
            acc_next = sat34(prod_shift[33:0]);
        end
        else if (ctl.add && ctl.spike)
        begin
            acc_next = sat34(34'(sum));
        end

        mem_next = mem_reg;
        if (load_en)
        begin
            mem_next = load_value;
        end
        else if (ctl.fire)
        begin
            if (!at_threshold)
                mem_next = acc_reg;
            else if (hard_mode)
                mem_next = reset_eff;
            else
                mem_next = sat34(34'(diff));
        end
    end

    // Membrane potential.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_reg <= '0;
        end
        else
        begin
            mem_reg <= mem_next;
        end
    end

    // Working registers of the timestep.
    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    assign mem_value = mem_reg;
    assign fired     = at_threshold;

endmodule

@@ design/lifdl_ctrl.sv @@
// ============================================================================
// lifdl_ctrl
// Request sequencer: handshakes, timestep schedule and result register flag.
// ============================================================================
`include "lif_dense_layer_step_assert.svh"

module lifdl_ctrl
    import lifdl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic [1:0]  req_type,
    input  logic [15:0] in_spikes,
    input  logic        rsp_ready,
    output logic        req_ready,
    output logic        rsp_valid,
    output lane_ctl_t   lane_ctl,
    output rsp_ctl_t    rsp_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_NORM,
        S_ACC,
        S_FIRE
    } state_t;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SPIKE_ROWS - 1);

    state_t                  state_reg, state_next;
    logic [ROW_W-1:0]        row_reg, row_next;
    logic [SPIKE_ROWS-1:0]   spikes_reg, spikes_next;
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    out_free;
    logic                    is_step;
    logic                    accept;

    // Next-state and command decode.
    always_comb
    begin
        out_free  = !rsp_valid_reg || rsp_ready;
        is_step   = (req_type == REQ_STEP);
        req_ready = (state_reg == S_IDLE) && (out_free || is_step);
        accept    = req_valid && req_ready;

        lane_ctl    = '0;
        rsp_ctl     = '0;
        state_next  = state_reg;
        row_next    = row_reg;
        spikes_next = spikes_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (is_step)
                    begin
                        state_next  = S_MUL;
                        row_next    = '0;
                        spikes_next = in_spikes[SPIKE_ROWS-1:0];
                    end
                    else
                    begin
                        rsp_ctl.load = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                lane_ctl.mul = 1'b1;
                state_next   = S_NORM;
            end
            S_NORM:
            begin
                lane_ctl.norm    = 1'b1;
                lane_ctl.rd_addr = '0;
                state_next       = S_ACC;
            end
            S_ACC:
            begin
                lane_ctl.add   = 1'b1;
                lane_ctl.spike = spikes_reg[0];
                spikes_next    = spikes_reg >> 1;
                if (row_reg == LAST_ROW)
                begin
                    state_next = S_FIRE;
                end
                else
                begin
                    row_next         = row_reg + 1'b1;
                    lane_ctl.rd_addr = row_reg + 1'b1;
                end
            end
            S_FIRE:
            begin
                if (out_free)
                begin
                    lane_ctl.fire = 1'b1;
                    rsp_ctl.load  = 1'b1;
                    rsp_ctl.step  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (rsp_ctl.load)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            spikes_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            spikes_reg    <= spikes_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // A waiting result is never overwritten.
    `LIFDL_ASSERT(a_no_overwrite, (rsp_valid_reg && !rsp_ready) |-> !rsp_ctl.load)
    // The leak product is always followed by its normalization.
    `LIFDL_ASSERT(a_mul_then_norm, lane_ctl.mul |=> lane_ctl.norm)
    // Lanes fire only after the last row was added or while the result waited.
    `LIFDL_ASSERT(a_fire_order, lane_ctl.fire |-> ($past(lane_ctl.add) || $past(state_reg == S_FIRE)))
    // After a timestep the result is shown and the sequencer is free again.
    `LIFDL_ASSERT(a_step_done, lane_ctl.fire |=> (rsp_valid_reg && state_reg == S_IDLE))
    // Reset leaves no result pending and the sequencer idle.
    `LIFDL_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!rsp_valid_reg && state_reg == S_IDLE))

endmodule
